// ----- src/rds_pkg.sv -----
// Shared types and constants for the RGBA 2x downsampler.
// Used by the core, the divider, both checkers and the bench; depends on nothing.
package rds_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 13;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int NUM_COL    = 3;
    localparam int CH_ALPHA   = 3;
    localparam int SUM_W      = CH_W + 2;
    localparam int PROD_W     = 2 * CH_W;
    localparam int WSUM_W     = PROD_W + 2;
    localparam int NUM_W      = WSUM_W + 1;
    localparam int DEN_W      = SUM_W + 1;
    localparam int QSTEP_W    = $clog2(CH_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_WEIGHTED = 2'd2;

    // channel 0 is red, channel 3 is alpha
    typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic            frame_end;
    } out_item_t;

endpackage

// ----- src/rds_divide.sv -----
// Three-lane restoring divider, one quotient bit per cycle, for the alpha-weighted colours.
// Depends on rds_pkg. Quotient must fit in CH_W bits (num < den << CH_W).
module rds_divide (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [rds_pkg::NUM_COL-1:0][rds_pkg::NUM_W-1:0] num,
    input  logic [rds_pkg::DEN_W-1:0]                 den,
    output logic                                      done,
    output logic [rds_pkg::NUM_COL-1:0][rds_pkg::CH_W-1:0]  quot
);

    logic                                             run_reg;
    logic                                             done_reg;
    logic [rds_pkg::QSTEP_W-1:0]                      step_reg;
    logic [rds_pkg::DEN_W-1:0]                        den_reg;
    logic [rds_pkg::NUM_COL-1:0][rds_pkg::NUM_W-1:0]  rem_reg;
    logic [rds_pkg::NUM_COL-1:0][rds_pkg::CH_W-1:0]   quot_reg;

    logic [rds_pkg::NUM_W-1:0]                        dsh;
    logic [rds_pkg::NUM_COL-1:0][rds_pkg::NUM_W-1:0]  trial;
    logic [rds_pkg::NUM_COL-1:0]                      take;

    always_comb
    begin
        dsh = rds_pkg::NUM_W'(den_reg) << step_reg;
        for (int k = 0; k < rds_pkg::NUM_COL; k++)
        begin
            take[k]  = rem_reg[k] >= dsh;
            trial[k] = rem_reg[k] - dsh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= rds_pkg::QSTEP_W'(rds_pkg::CH_W - 1);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - rds_pkg::QSTEP_W'(1);
                if (step_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= num;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            for (int k = 0; k < rds_pkg::NUM_COL; k++)
            begin
                if (take[k])
                    rem_reg[k] <= trial[k];
                quot_reg[k][step_reg] <= take[k];
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- src/rgba_downsample_2x_core.sv -----
// A source item that completes a 2x2 block passes ST_PROD, ST_SUM, ST_DIV (alpha-weighted mode with
// a nonzero alpha sum only) and ST_DONE, which loads its result into the output register.
// Throughput: items that complete no block are taken one per cycle; after one that does,
// input is held off until its result enters the output register, in alpha-weighted mode
// after the 8-step shared divider. Reset clears the position counters, the held pixel, the
// state and output register; line store not cleared (no clearing pass), each entry written before read.
module rgba_downsample_2x_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [rds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             source_valid,
    output logic                             source_ready,
    input  rds_pkg::in_item_t                source_pixel,
    output logic                             mip_valid,
    input  logic                             mip_ready,
    output rds_pkg::out_item_t               mip_pixel
);

    typedef enum logic [2:0] {ST_IDLE, ST_PROD, ST_SUM, ST_DIV, ST_DONE} state_t;

    // configuration and position
    logic [rds_pkg::DIM_W-1:0] width_reg;
    logic [rds_pkg::DIM_W-1:0] height_reg;
    logic                      weighted_reg;
    logic [rds_pkg::COL_W-1:0] col_reg;
    logic [rds_pkg::ROW_W-1:0] row_reg;
    rds_pkg::pixel_t           held_reg;

    // line store
    rds_pkg::pixel_t           mem [rds_pkg::MAX_WIDTH];
    rds_pkg::pixel_t           mem_rdata_reg;
    rds_pkg::pixel_t           top_hold_reg;
    logic                      rd_pend_reg;

    // per-item work registers
    state_t                    state_reg;
    rds_pkg::pixel_t           p_cur_reg;
    rds_pkg::pixel_t           p_held_reg;
    logic                      p_w1_reg;
    logic                      p_h1_reg;
    logic                      p_end_reg;
    logic [rds_pkg::NUM_CH-1:0][rds_pkg::SUM_W-1:0]                          sum_reg;
    logic [rds_pkg::NUM_CH-1:0][rds_pkg::NUM_COL-1:0][rds_pkg::PROD_W-1:0]   prod_reg;

    logic                      out_valid_reg;
    rds_pkg::out_item_t        out_item_reg;

    // combinational
    rds_pkg::pixel_t           cur;
    logic [rds_pkg::DIM_W-1:0] w_eff;
    logic [rds_pkg::DIM_W-1:0] h_eff;
    logic                      w_one;
    logic                      h_one;
    logic [rds_pkg::DIM_W-1:0] lastx_full;
    logic [rds_pkg::DIM_W-1:0] lasty_full;
    logic [rds_pkg::COL_W-1:0] lastx;
    logic [rds_pkg::ROW_W-1:0] lasty;
    logic                      col_ok;
    logic                      row_ok;
    logic                      emit;
    logic                      accept;
    logic [rds_pkg::DIM_W-1:0] col_inc;
    logic [rds_pkg::DIM_W-1:0] row_inc;
    logic                      mem_we;
    logic                      mem_re;

    logic [rds_pkg::NUM_CH-1:0][rds_pkg::CH_W-1:0]                           quad_ch [4];
    rds_pkg::pixel_t           q_bl;
    rds_pkg::pixel_t           q_tl;
    rds_pkg::pixel_t           q_tr;
    logic [rds_pkg::NUM_CH-1:0][rds_pkg::SUM_W-1:0]                          sum_c;
    logic [rds_pkg::NUM_CH-1:0][rds_pkg::NUM_COL-1:0][rds_pkg::PROD_W-1:0]   prod_c;

    logic [rds_pkg::NUM_COL-1:0][rds_pkg::WSUM_W-1:0] wsum;
    logic [rds_pkg::NUM_COL-1:0][rds_pkg::NUM_W-1:0]  div_num;
    logic [rds_pkg::DEN_W-1:0]                        div_den;
    logic                                             div_start;
    logic                                             div_done;
    logic [rds_pkg::NUM_COL-1:0][rds_pkg::CH_W-1:0]   div_quot;
    logic                                             alpha_zero;
    logic [rds_pkg::NUM_CH-1:0][rds_pkg::SUM_W-1:0]   rounded;
    rds_pkg::pixel_t                                  result;
    logic                                             out_free;

    assign cur = {source_pixel.in_alpha, source_pixel.in_blue,
                  source_pixel.in_green, source_pixel.in_red};

    always_comb
    begin
        if (width_reg == '0)
            w_eff = rds_pkg::DIM_W'(1);
        else if (width_reg > rds_pkg::DIM_W'(rds_pkg::MAX_WIDTH))
            w_eff = rds_pkg::DIM_W'(rds_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = rds_pkg::DIM_W'(1);
        else if (height_reg > rds_pkg::DIM_W'(rds_pkg::MAX_HEIGHT))
            h_eff = rds_pkg::DIM_W'(rds_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign w_one      = w_eff == rds_pkg::DIM_W'(1);
    assign h_one      = h_eff == rds_pkg::DIM_W'(1);
    assign lastx_full = {w_eff[rds_pkg::DIM_W-1:1], 1'b0} - rds_pkg::DIM_W'(1);
    assign lasty_full = {h_eff[rds_pkg::DIM_W-1:1], 1'b0} - rds_pkg::DIM_W'(1);
    assign lastx      = w_one ? '0 : lastx_full[rds_pkg::COL_W-1:0];
    assign lasty      = h_one ? '0 : lasty_full[rds_pkg::ROW_W-1:0];
    assign col_ok     = w_one ? (col_reg == '0) : (col_reg[0] && col_reg <= lastx);
    assign row_ok     = h_one ? (row_reg == '0) : (row_reg[0] && row_reg <= lasty);
    assign emit       = col_ok && row_ok;

    assign source_ready = state_reg == ST_IDLE;
    assign accept       = source_valid && source_ready;
    assign col_inc      = rds_pkg::DIM_W'(col_reg) + rds_pkg::DIM_W'(1);
    assign row_inc      = rds_pkg::DIM_W'(row_reg) + rds_pkg::DIM_W'(1);

    // even rows fill the store, odd rows read it back; never both on one item
    assign mem_we = accept && !row_reg[0];
    assign mem_re = accept && row_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= rds_pkg::DIM_W'(1);
            height_reg   <= rds_pkg::DIM_W'(1);
            weighted_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            held_reg     <= '0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= mem_re;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    rds_pkg::CFG_SOURCE_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    rds_pkg::CFG_SOURCE_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    rds_pkg::CFG_ALPHA_WEIGHTED:
                    begin
                        weighted_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (accept)
            begin
                held_reg <= cur;
                if (col_inc >= w_eff)
                begin
                    col_reg <= '0;
                    if (row_inc >= h_eff)
                        row_reg <= '0;
                    else
                        row_reg <= row_inc[rds_pkg::ROW_W-1:0];
                end
                else
                begin
                    col_reg <= col_inc[rds_pkg::COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[col_reg] <= cur;
        if (mem_re)
            mem_rdata_reg <= mem[col_reg];
    end

    // keeps the top pixel of the previous column for the top-left sample
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
            top_hold_reg <= mem_rdata_reg;
    end

    // 2x2 gather, channel sums and colour-by-alpha products
    always_comb
    begin
        q_bl = p_w1_reg ? p_cur_reg : p_held_reg;
        q_tl = p_h1_reg ? q_bl : (p_w1_reg ? mem_rdata_reg : top_hold_reg);
        q_tr = p_h1_reg ? p_cur_reg : mem_rdata_reg;
        quad_ch[0] = q_tl;
        quad_ch[1] = q_tr;
        quad_ch[2] = q_bl;
        quad_ch[3] = p_cur_reg;
        for (int k = 0; k < rds_pkg::NUM_CH; k++)
        begin
            sum_c[k] = '0;
            for (int i = 0; i < 4; i++)
                sum_c[k] = sum_c[k] + rds_pkg::SUM_W'(quad_ch[i][k]);
        end
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < rds_pkg::NUM_COL; k++)
                prod_c[i][k] = rds_pkg::PROD_W'(quad_ch[i][k])
                             * rds_pkg::PROD_W'(quad_ch[i][rds_pkg::CH_ALPHA]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < rds_pkg::NUM_COL; k++)
        begin
            wsum[k] = '0;
            for (int i = 0; i < 4; i++)
                wsum[k] = wsum[k] + rds_pkg::WSUM_W'(prod_reg[i][k]);
            div_num[k] = {wsum[k], 1'b0} + rds_pkg::NUM_W'(sum_reg[rds_pkg::CH_ALPHA]);
        end
        div_den = {sum_reg[rds_pkg::CH_ALPHA], 1'b0};
    end

    assign alpha_zero = sum_reg[rds_pkg::CH_ALPHA] == '0;
    assign div_start  = (state_reg == ST_SUM) && weighted_reg && !alpha_zero;

    rds_divide u_divide (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // (sum + 2) / 4 for plain channels and for alpha
    always_comb
    begin
        for (int k = 0; k < rds_pkg::NUM_CH; k++)
        begin
            rounded[k] = sum_reg[k] + rds_pkg::SUM_W'(2);
            result[k]  = rounded[k][rds_pkg::SUM_W-1:2];
        end
        if (weighted_reg)
        begin
            for (int k = 0; k < rds_pkg::NUM_COL; k++)
                result[k] = alpha_zero ? '0 : div_quot[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            p_cur_reg  <= cur;
            p_held_reg <= held_reg;
            p_w1_reg   <= w_one;
            p_h1_reg   <= h_one;
            p_end_reg  <= (col_reg == lastx) && (row_reg == lasty);
        end
        if (state_reg == ST_PROD)
        begin
            sum_reg  <= sum_c;
            prod_reg <= prod_c;
        end
    end

    assign out_free = !out_valid_reg || mip_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            // in ST_DONE the load below decides the valid flag
            if (mip_ready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && emit)
                        state_reg <= ST_PROD;
                end
                ST_PROD:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= div_start ? ST_DIV : ST_DONE;
                end
                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_item_reg.out_red    <= result[0];
                        out_item_reg.out_green  <= result[1];
                        out_item_reg.out_blue   <= result[2];
                        out_item_reg.out_alpha  <= result[rds_pkg::CH_ALPHA];
                        out_item_reg.frame_end  <= p_end_reg;
                        state_reg               <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign mip_valid = out_valid_reg;
    assign mip_pixel = out_item_reg;

endmodule

// ----- src/rds_checker.sv -----
// Port-level checks for rgba_downsample_2x_core, attached by the bind at the end.
// Depends on rds_pkg and sees the top level's ports only.
module rds_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_write_en,
    input logic [rds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [rds_pkg::CFG_DATA_W-1:0]   cfg_data,
    input logic                             source_valid,
    input logic                             source_ready,
    input rds_pkg::in_item_t                source_pixel,
    input logic                             mip_valid,
    input logic                             mip_ready,
    input rds_pkg::out_item_t               mip_pixel
);

    // a waiting result item holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        mip_valid && !mip_ready |=> mip_valid && $stable(mip_pixel))
        else $error("result item changed while stalled");

    // a result item is loaded only while the input side is held off
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mip_valid) |-> !$past(source_ready))
        else $error("result appeared while input was open");

    // the input closes only after an item was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(source_ready) |-> $past(source_valid))
        else $error("input closed without an accepted item");

    // once a result-producing item closes the input, the input does not reopen at once
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(source_ready) |=> !source_ready)
        else $error("input reopened too early");

endmodule

bind rgba_downsample_2x_core rds_checker u_rds_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .source_valid (source_valid),
    .source_ready (source_ready),
    .source_pixel (source_pixel),
    .mip_valid    (mip_valid),
    .mip_ready    (mip_ready),
    .mip_pixel    (mip_pixel)
);

// ----- tb/rds_mip_checker.sv -----
// Port checker for the RGBA 2x downsampler: mirrors the register writes, predicts every mip item
// from the accepted source items and compares it with the output channel.
// Depends on rds_pkg for the item types, register indexes and size limits.
module rds_mip_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [rds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           source_valid,
    input  logic                           source_ready,
    input  rds_pkg::in_item_t              source_pixel,
    input  logic                           mip_valid,
    input  logic                           mip_ready,
    input  rds_pkg::out_item_t             mip_pixel,
    output int                             mismatch_count,
    output int                             results_owed,
    output int                             mips_matched
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 50;

    rds_pkg::pixel_t             line_buf [rds_pkg::MAX_WIDTH];
    rds_pkg::pixel_t             held;
    int unsigned                 col;
    int unsigned                 row;
    logic [rds_pkg::DIM_W-1:0]   width_reg;
    logic [rds_pkg::DIM_W-1:0]   height_reg;
    logic                        weighted;
    rds_pkg::out_item_t          mip_expected [$];
    int                          errs = 0;
    int                          checked = 0;

    function automatic int unsigned clamp_dim(input logic [rds_pkg::DIM_W-1:0] v,
                                              input int unsigned lim);
        if (v == '0)
            return 1;
        if (32'(v) > lim)
            return lim;
        return 32'(v);
    endfunction

    // colours: plain (sum+2)/4, or alpha-weighted mean rounded half up; alpha always plain
    function automatic rds_pkg::out_item_t box_filter(input rds_pkg::pixel_t tl,
                                                      input rds_pkg::pixel_t tr,
                                                      input rds_pkg::pixel_t bl,
                                                      input rds_pkg::pixel_t br,
                                                      input logic wt, input logic last);
        rds_pkg::pixel_t          q [4];
        int unsigned              sum [4];
        int unsigned              wsum [3];
        int unsigned              v;
        logic [rds_pkg::CH_W-1:0] res [4];
        rds_pkg::out_item_t       r;
        int                       i;
        int                       k;
        q[0] = tl;
        q[1] = tr;
        q[2] = bl;
        q[3] = br;
        for (k = 0; k < rds_pkg::NUM_CH; k++)
            sum[k] = 0;
        for (k = 0; k < rds_pkg::NUM_COL; k++)
            wsum[k] = 0;
        for (i = 0; i < 4; i++)
        begin
            for (k = 0; k < rds_pkg::NUM_CH; k++)
                sum[k] += 32'(q[i][k]);
            for (k = 0; k < rds_pkg::NUM_COL; k++)
                wsum[k] += 32'(q[i][k]) * 32'(q[i][rds_pkg::CH_ALPHA]);
        end
        for (k = 0; k < rds_pkg::NUM_CH; k++)
        begin
            if (wt && k < rds_pkg::NUM_COL)
                v = (sum[rds_pkg::CH_ALPHA] == 0) ? 0 :
                    (2 * wsum[k] + sum[rds_pkg::CH_ALPHA]) / (2 * sum[rds_pkg::CH_ALPHA]);
            else
                v = (sum[k] + 2) / 4;
            if (v > 255)
                v = 255;
            res[k] = v[rds_pkg::CH_W-1:0];
        end
        r.out_red   = res[0];
        r.out_green = res[1];
        r.out_blue  = res[2];
        r.out_alpha = res[3];
        r.frame_end = last;
        return r;
    endfunction

    task automatic apply_write(input logic [rds_pkg::CFG_IDX_W-1:0] idx,
                               input logic [rds_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            rds_pkg::CFG_SOURCE_WIDTH:
            begin
                width_reg = data;
                col = 0;
                row = 0;
            end
            rds_pkg::CFG_SOURCE_HEIGHT:
            begin
                height_reg = data;
                col = 0;
                row = 0;
            end
            rds_pkg::CFG_ALPHA_WEIGHTED:
                weighted = data[0];
            default:
                ;
        endcase
    endtask

    task automatic take_source_pixel(input rds_pkg::in_item_t p);
        int unsigned     w;
        int unsigned     h;
        int unsigned     x;
        int unsigned     y;
        int unsigned     xl;
        int unsigned     lastx;
        int unsigned     lasty;
        bit              colok;
        bit              rowok;
        rds_pkg::pixel_t cur;
        rds_pkg::pixel_t left;
        rds_pkg::pixel_t top_l;
        rds_pkg::pixel_t top_r;
        w = clamp_dim(width_reg, rds_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, rds_pkg::MAX_HEIGHT);
        x = col;
        y = row;
        cur = {p.in_alpha, p.in_blue, p.in_green, p.in_red};
        lastx = (w == 1) ? 0 : 2 * (w / 2) - 1;
        lasty = (h == 1) ? 0 : 2 * (h / 2) - 1;
        colok = (w == 1) ? (x == 0) : (x[0] && x <= lastx);
        rowok = (h == 1) ? (y == 0) : (y[0] && y <= lasty);
        if (colok && rowok)
        begin
            // single column / single row: the pixel stands in for its missing neighbour
            left = (w == 1) ? cur : held;
            if (h == 1)
            begin
                top_l = left;
                top_r = cur;
            end
            else
            begin
                xl = (w == 1) ? x : x - 1;
                top_l = line_buf[xl[rds_pkg::COL_W-1:0]];
                top_r = line_buf[x[rds_pkg::COL_W-1:0]];
            end
            mip_expected.insert(mip_expected.size(),
                                box_filter(top_l, top_r, left, cur, weighted,
                                           x == lastx && y == lasty));
        end
        if (!y[0] && x < rds_pkg::MAX_WIDTH)
            line_buf[x[rds_pkg::COL_W-1:0]] = cur;
        held = cur;
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h)
                y = 0;
        end
        col = x;
        row = y;
    endtask

    task automatic report(input string msg);
        if (errs < MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, msg);
        errs++;
    endtask

    task automatic compare_field(input string name, input logic [rds_pkg::CH_W-1:0] got,
                                 input logic [rds_pkg::CH_W-1:0] want);
        if (got !== want)
            report($sformatf("mip item %0d %s is %0d, expected %0d", checked, name, got, want));
    endtask

    task automatic check_result(input rds_pkg::out_item_t got);
        rds_pkg::out_item_t want;
        if (mip_expected.size() == 0)
        begin
            report($sformatf("mip item %0d arrived with none expected", checked));
        end
        else
        begin
            want = mip_expected.pop_front();
            compare_field("red", got.out_red, want.out_red);
            compare_field("green", got.out_green, want.out_green);
            compare_field("blue", got.out_blue, want.out_blue);
            compare_field("alpha", got.out_alpha, want.out_alpha);
            compare_field("frame_end", rds_pkg::CH_W'(got.frame_end),
                          rds_pkg::CH_W'(want.frame_end));
        end
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col        = 0;
            row        = 0;
            width_reg  = rds_pkg::DIM_W'(1);
            height_reg = rds_pkg::DIM_W'(1);
            weighted   = 1'b0;
            held       = '0;
            mip_expected.delete();
            results_owed   <= 0;
            mismatch_count <= errs;
            mips_matched   <= checked;
        end
        else
        begin
            if (cfg_write_en)
                apply_write(cfg_index, cfg_data);
            if (source_valid && source_ready)
                take_source_pixel(source_pixel);
            if (mip_valid && mip_ready)
                check_result(mip_pixel);
            results_owed   <= mip_expected.size();
            mismatch_count <= errs;
            mips_matched   <= checked;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the RGBA 2x downsampler bench: clock, reset, register writes, source and sink traffic.
// Instantiates rgba_downsample_2x_core and rds_mip_checker; types come from rds_pkg.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 350;
    localparam int CYCLE_LIMIT   = 400000;

    // index with no register behind it
    localparam logic [rds_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write_en = 1'b0;
    logic [rds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rds_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           source_valid = 1'b0;
    logic                           source_ready;
    rds_pkg::in_item_t              source_pixel = '0;
    logic                           mip_valid;
    logic                           mip_ready = 1'b0;
    rds_pkg::out_item_t             mip_pixel;

    int          mismatch_count;
    int          results_owed;
    int          mips_matched;

    int          cycle_count = 0;
    int          snd_idle = 0;
    int          rcv_idle = 0;
    int          hold_requests = 0;
    int          holds_done = 0;
    int          hold_left = 0;
    int          items_sent = 0;
    int          reg_writes = 0;
    int unsigned cur_w = 1;
    int unsigned cur_h = 1;

    rgba_downsample_2x_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .source_valid (source_valid),
        .source_ready (source_ready),
        .source_pixel (source_pixel),
        .mip_valid    (mip_valid),
        .mip_ready    (mip_ready),
        .mip_pixel    (mip_pixel)
    );

    rds_mip_checker mip_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .source_valid   (source_valid),
        .source_ready   (source_ready),
        .source_pixel   (source_pixel),
        .mip_valid      (mip_valid),
        .mip_ready      (mip_ready),
        .mip_pixel      (mip_pixel),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .mips_matched   (mips_matched)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // sink: random ready, or a long hold-off whenever the stimulus asks for one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mip_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            mip_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_done != hold_requests)
        begin
            holds_done <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            mip_ready  <= 1'b0;
        end
        else
        begin
            mip_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    function automatic int unsigned eff_dim(input int unsigned v, input int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic rds_pkg::in_item_t px(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] a);
        rds_pkg::in_item_t p;
        p.in_red   = r;
        p.in_green = g;
        p.in_blue  = b;
        p.in_alpha = a;
        return p;
    endfunction

    // sparse frames are mostly transparent so that all-zero alpha blocks turn up
    function automatic rds_pkg::in_item_t rand_pixel(input bit sparse);
        rds_pkg::in_item_t p;
        p = rds_pkg::in_item_t'($urandom);
        case ($urandom_range(7))
            0: p = px(8'h00, 8'h00, 8'h00, p.in_alpha);
            1: p = px(8'hFF, 8'hFF, 8'hFF, p.in_alpha);
            default: ;
        endcase
        if (sparse && $urandom_range(4) != 0)
            p.in_alpha = 8'h00;
        else
            case ($urandom_range(7))
                0: p.in_alpha = 8'h00;
                1: p.in_alpha = 8'hFF;
                2: p.in_alpha = 8'($urandom_range(1, 3));
                default: ;
            endcase
        return p;
    endfunction

    task automatic send_source_pixel(input rds_pkg::in_item_t p);
        while ($urandom_range(99) < snd_idle)
        begin
            source_valid <= 1'b0;
            @(posedge clk);
        end
        source_valid <= 1'b1;
        source_pixel <= p;
        @(posedge clk);
        while (!source_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // wait until every predicted item has come out and the pipeline has emptied
    task automatic drain_mips();
        source_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rds_pkg::CFG_IDX_W-1:0] idx, input int unsigned data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data[rds_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        reg_writes++;
        if (idx == rds_pkg::CFG_SOURCE_WIDTH)
            cur_w = 32'(data[rds_pkg::CFG_DATA_W-1:0]);
        else if (idx == rds_pkg::CFG_SOURCE_HEIGHT)
            cur_h = 32'(data[rds_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic close_writes();
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_frame(input int unsigned w, input int unsigned h,
                                 input int unsigned wt);
        drain_mips();
        write_reg(rds_pkg::CFG_SOURCE_WIDTH, w);
        write_reg(rds_pkg::CFG_SOURCE_HEIGHT, h);
        write_reg(rds_pkg::CFG_ALPHA_WEIGHTED, wt);
        close_writes();
    endtask

    task automatic feed_pixels(input int unsigned n, input bit sparse, input int unsigned drain_at);
        int unsigned i;
        for (i = 0; i < n; i++)
        begin
            if (i == drain_at)
                drain_mips();
            send_source_pixel(rand_pixel(sparse));
        end
    endtask

    task automatic run_random_frame();
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned frame_px;
        int unsigned drain_at;
        bit          sparse;
        sel = $urandom_range(99);
        sparse = ($urandom_range(3) == 0);
        if (sel < 15)
        begin
            // mode change only: geometry and position carry on
            drain_mips();
            write_reg(rds_pkg::CFG_ALPHA_WEIGHTED, $urandom_range(8191));
            if ($urandom_range(1))
                write_reg(CFG_UNUSED, $urandom_range(8191));
            close_writes();
        end
        else
        begin
            case ($urandom_range(19))
                0:
                begin
                    w = $urandom_range(8191);
                    h = $urandom_range(8191);
                end
                1:
                begin
                    w = $urandom_range(1);
                    h = $urandom_range(12);
                end
                2:
                begin
                    w = $urandom_range(12);
                    h = $urandom_range(1);
                end
                3:
                begin
                    w = $urandom_range(16, 70);
                    h = $urandom_range(2, 5);
                end
                default:
                begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(1, 12);
                end
            endcase
            program_frame(w, h, $urandom_range(8191));
        end
        frame_px = eff_dim(cur_w, rds_pkg::MAX_WIDTH) * eff_dim(cur_h, rds_pkg::MAX_HEIGHT);
        n = frame_px * $urandom_range(1, 2);
        if (sel >= 15 && sel < 30)
            n = $urandom_range(1, frame_px);   // frame cut short by the next write
        if (n > 300)
            n = $urandom_range(20, 300);
        drain_at = ($urandom_range(5) == 0) ? n / 2 : n;
        feed_pixels(n, sparse, drain_at);
    endtask

    task automatic run_directed();
        // reset geometry is 1x1, plain: every item gives a frame-ending mip item
        send_source_pixel(px(8'h00, 8'h00, 8'h00, 8'h00));
        send_source_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        drain_mips();
        write_reg(rds_pkg::CFG_ALPHA_WEIGHTED, 1);
        close_writes();
        send_source_pixel(px(8'hFF, 8'h00, 8'h80, 8'h01));
        send_source_pixel(px(8'h12, 8'h34, 8'h56, 8'h00));

        // 3x3 weighted: trailing column and row dropped; unused index mid-frame
        program_frame(3, 3, 1);
        send_source_pixel(px(8'hFF, 8'h00, 8'h01, 8'hFF));
        send_source_pixel(px(8'h00, 8'hFF, 8'hFE, 8'h00));
        send_source_pixel(px(8'hAA, 8'h55, 8'h33, 8'h80));
        send_source_pixel(px(8'h01, 8'h80, 8'hFF, 8'h01));
        drain_mips();
        write_reg(CFG_UNUSED, 8191);
        close_writes();
        send_source_pixel(px(8'h7F, 8'h7F, 8'h7F, 8'hFE));
        send_source_pixel(px(8'h10, 8'h20, 8'h30, 8'h40));
        send_source_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_source_pixel(px(8'h00, 8'h00, 8'h00, 8'hFF));
        send_source_pixel(px(8'h55, 8'hAA, 8'hCC, 8'h7F));

        // zero width acts as one column
        program_frame(0, 2, 0);
        send_source_pixel(px(8'hFF, 8'h01, 8'h02, 8'h03));
        send_source_pixel(px(8'h00, 8'hFE, 8'hFD, 8'hFC));

        // width beyond the line store clamps; single row
        program_frame(8191, 1, 1);
        send_source_pixel(px(8'h80, 8'h40, 8'h20, 8'h00));
        send_source_pixel(px(8'h01, 8'h02, 8'h04, 8'h00));

        // widest and tallest, then a width write restarts the frame part way through
        program_frame(rds_pkg::MAX_WIDTH, 8191, 0);
        send_source_pixel(px(8'hDE, 8'hAD, 8'hBE, 8'hEF));
        send_source_pixel(px(8'h01, 8'h23, 8'h45, 8'h67));
        drain_mips();
        write_reg(rds_pkg::CFG_SOURCE_WIDTH, 2);
        close_writes();
        send_source_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_source_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'hFE));
        send_source_pixel(px(8'h00, 8'h00, 8'h00, 8'h01));
        send_source_pixel(px(8'h00, 8'h01, 8'h00, 8'h00));
        drain_mips();
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int phase_start;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle = 22;
        rcv_idle <= 63;
        run_directed();

        for (phase = 0; phase < 3; phase++)
        begin
            snd_idle = (phase == 0) ? 22 : (phase == 1) ? 63 : 0;
            rcv_idle <= (phase == 0) ? 63 : (phase == 1) ? 22 : 0;
            phase_start = items_sent;
            if (phase == 2)
            begin
                // output stalled for a long stretch while the source keeps offering items
                program_frame(16, 8, 1);
                hold_requests <= hold_requests + 1;
                feed_pixels(128, 1'b0, 96);
            end
            while (items_sent < phase_start + PHASE_ITEMS)
                run_random_frame();
        end

        drain_mips();
        $display("Covered %0d source items, %0d mip items checked, %0d register writes,",
                 items_sent, mips_matched, reg_writes);
        $display("both filter modes, clamped and single-pixel sizes, three idle mixes, one long stall");
        if (mismatch_count == 0 && results_owed == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
